### rtl/ir_pulse_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// IR pulse frame decoder assertion macros
// Shared property shapes for the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, suspended while reset is high.
`define IRPFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, suspended while reset is high.
`define IRPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define IRPFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/irpfd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder package
// Types, register map, widths and the key code table shared by the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irpfd_pkg;

   localparam int REG_W        = 24;
   localparam int EDGE_TICK_W  = 32;
   localparam int FRAME_WORD_W = 32;
   localparam int KEY_CODE_W   = 5;
   localparam int REQ_W        = 32;
   localparam int RSP_W        = 40;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int EDGE_COUNT_W = 8;
   localparam int BIT_IDX_W    = 7;
   localparam int NUM_CODES    = 16;
   localparam int LOOKUP_W     = 64;

   localparam logic [EDGE_COUNT_W-1:0] EDGE_COUNT_MAX = 8'd255;
   localparam logic [EDGE_COUNT_W-1:0] START_EDGE     = 8'd3;

   localparam logic [REG_W-1:0] FRAME_TICKS_RST    = 24'd5600000;
   localparam logic [REG_W-1:0] COOLDOWN_TICKS_RST = 24'd2640000;
   localparam logic [REG_W-1:0] ONE_LOW_RST        = 24'd190000;
   localparam logic [REG_W-1:0] ONE_HIGH_RST       = 24'd200000;
   localparam logic [REG_W-1:0] RESYNC_LOW_RST     = 24'd70000;
   localparam logic [REG_W-1:0] RESYNC_HIGH_RST    = 24'd74000;

   localparam logic [KEY_CODE_W-1:0] NO_KEY = 5'd0;

   typedef enum logic [2:0] {
      REG_FRAME_TICKS    = 3'd0,
      REG_COOLDOWN_TICKS = 3'd1,
      REG_ONE_LOW        = 3'd2,
      REG_ONE_HIGH       = 3'd3,
      REG_RESYNC_LOW     = 3'd4,
      REG_RESYNC_HIGH    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [REG_W-1:0] frame_ticks;
      logic [REG_W-1:0] cooldown_ticks;
      logic [REG_W-1:0] one_low;
      logic [REG_W-1:0] one_high;
      logic [REG_W-1:0] resync_low;
      logic [REG_W-1:0] resync_high;
   } cfg_type;

   // Code words of the remote, in key order; a match at entry i yields key i+1.
   localparam logic [REG_W-1:0] CODE_WORDS [NUM_CODES] = '{
      24'h596A69, 24'h8167E9, 24'h796869, 24'h7568A9,
      24'h7168E9, 24'h6D6929, 24'h696969, 24'h6569A9,
      24'h6169E9, 24'h5D6A29, 24'h316CE9, 24'hC563A9,
      24'h3D6C29, 24'h396C69, 24'hBD6429, 24'hDD6229
   };

   function automatic logic [KEY_CODE_W-1:0] lookup_key(input logic [LOOKUP_W-1:0] word);
      logic [KEY_CODE_W-1:0] key;
      key = NO_KEY;
      // Entries are distinct, so at most one compare matches.
      for (int i = 0; i < NUM_CODES; i++) begin
         if (word == LOOKUP_W'(CODE_WORDS[i])) begin
            key = KEY_CODE_W'(i + 1);
         end
      end
      return key;
   endfunction

endpackage

`default_nettype wire

### rtl/ir_pulse_frame_decoder.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder
// Decodes pulse-distance remote frames from timestamped receiver edges.
// ----------------------------------------------------------------------------
//   Channel | Dir | Handshake         | Payload
//   req     | in  | tvalid / tready   | tdata: edge_tick
//   rsp     | out | tvalid / tready   | tdata: frame_word, key_code
//   csr     | in  | APB psel/penable  | six 24-bit timing registers
//
// One edge beat per cycle while no result waits on a stalled rsp; an edge
// passes through the input register, then the result register, and a frame
// that closes on it is shown on rsp from the result register.
// Reset is synchronous and returns all timing registers and frame state to defaults.
// While a result waits, an empty input register can still take one beat; the
// edge it then holds stalls req until the pending result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_frame_decoder #(
   parameter int TICK_BITS = 32,
   parameter int WORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [31:0] edge_tick
   input  wire logic [irpfd_pkg::REQ_W-1:0]        req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] frame_word, [36:32] key_code, [39:37] zero
   output logic      [irpfd_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [irpfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [irpfd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [irpfd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                    csr_pready
);

   irpfd_pkg::cfg_type                     cfg;
   logic                                   in_valid_ff, in_valid_in;
   logic [irpfd_pkg::EDGE_TICK_W-1:0]      in_tick_ff;
   logic                                   out_valid_ff, out_valid_in;
   logic [irpfd_pkg::FRAME_WORD_W-1:0]     out_word_ff;
   logic [irpfd_pkg::KEY_CODE_W-1:0]       out_key_ff;
   logic                                   advance;
   logic                                   closed;
   logic [irpfd_pkg::FRAME_WORD_W-1:0]     frame_word;
   logic [irpfd_pkg::KEY_CODE_W-1:0]       key_code;

   irpfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   irpfd_core #(
      .TICK_BITS (TICK_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .edge_tick  (in_tick_ff),
      .cfg        (cfg),
      .closed     (closed),
      .frame_word (frame_word),
      .key_code   (key_code)
   );

   // The held edge moves on only when the result register can take a result.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = (advance && closed) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tick_ff <= req_tdata[irpfd_pkg::EDGE_TICK_W-1:0];
      end
      if (advance && closed) begin
         out_word_ff <= frame_word;
         out_key_ff  <= key_code;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = irpfd_pkg::RSP_W'({out_key_ff, out_word_ff});

endmodule

`default_nettype wire

### rtl/irpfd_csr.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder register file
// APB-style access to the six 24-bit timing registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpfd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [irpfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [irpfd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [irpfd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                    csr_pready,
   output irpfd_pkg::cfg_type                      cfg
);

   irpfd_pkg::cfg_type cfg_ff;
   logic               wr_en;
   logic [2:0]         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[irpfd_pkg::CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_ticks    <= irpfd_pkg::FRAME_TICKS_RST;
         cfg_ff.cooldown_ticks <= irpfd_pkg::COOLDOWN_TICKS_RST;
         cfg_ff.one_low        <= irpfd_pkg::ONE_LOW_RST;
         cfg_ff.one_high       <= irpfd_pkg::ONE_HIGH_RST;
         cfg_ff.resync_low     <= irpfd_pkg::RESYNC_LOW_RST;
         cfg_ff.resync_high    <= irpfd_pkg::RESYNC_HIGH_RST;
      end else if (wr_en) begin
         case (reg_sel)
            irpfd_pkg::REG_FRAME_TICKS: begin
               cfg_ff.frame_ticks <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            irpfd_pkg::REG_COOLDOWN_TICKS: begin
               cfg_ff.cooldown_ticks <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            irpfd_pkg::REG_ONE_LOW: begin
               cfg_ff.one_low <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            irpfd_pkg::REG_ONE_HIGH: begin
               cfg_ff.one_high <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            irpfd_pkg::REG_RESYNC_LOW: begin
               cfg_ff.resync_low <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            irpfd_pkg::REG_RESYNC_HIGH: begin
               cfg_ff.resync_high <= csr_pwdata[irpfd_pkg::REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         irpfd_pkg::REG_FRAME_TICKS:    csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.frame_ticks);
         irpfd_pkg::REG_COOLDOWN_TICKS: csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.cooldown_ticks);
         irpfd_pkg::REG_ONE_LOW:        csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.one_low);
         irpfd_pkg::REG_ONE_HIGH:       csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.one_high);
         irpfd_pkg::REG_RESYNC_LOW:     csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.resync_low);
         irpfd_pkg::REG_RESYNC_HIGH:    csr_prdata = irpfd_pkg::CSR_DATA_W'(cfg_ff.resync_high);
         default:                       csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/irpfd_core.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder core
// Frame state and the per-edge update: timing, bit capture and frame close.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpfd_core #(
   parameter int TICK_BITS = 32,
   parameter int WORD_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic [irpfd_pkg::EDGE_TICK_W-1:0]    edge_tick,
   input  wire irpfd_pkg::cfg_type                   cfg,
   output logic                                      closed,
   output logic      [irpfd_pkg::FRAME_WORD_W-1:0]   frame_word,
   output logic      [irpfd_pkg::KEY_CODE_W-1:0]     key_code
);

   localparam int CW = (TICK_BITS > irpfd_pkg::REG_W) ? TICK_BITS : irpfd_pkg::REG_W;

   logic [TICK_BITS-1:0]                 last_edge_tick_ff, last_edge_tick_in;
   logic [TICK_BITS-1:0]                 frame_start_tick_ff, frame_start_tick_in;
   logic [TICK_BITS-1:0]                 frame_end_tick_ff, frame_end_tick_in;
   logic                                 edge_phase_ff, edge_phase_in;
   logic                                 start_seen_ff, start_seen_in;
   logic                                 awaiting_frame_ff, awaiting_frame_in;
   logic                                 in_cooldown_ff, in_cooldown_in;
   logic [irpfd_pkg::EDGE_COUNT_W-1:0]   edge_count_ff, edge_count_in;
   logic [WORD_BITS-1:0]                 data_word_ff, data_word_in;

   logic [TICK_BITS-1:0]                 now;
   logic [CW-1:0]                        delta;
   logic [CW-1:0]                        since_end;
   logic [CW-1:0]                        since_start;
   logic                                 cooldown_left;
   logic                                 frame_open;
   logic                                 start_mid;
   logic                                 active;
   logic                                 resync_hit;
   logic                                 one_hit;
   logic [irpfd_pkg::BIT_IDX_W-1:0]      bit_idx;
   logic [WORD_BITS-1:0]                 word_set;

   always_comb begin
      now         = TICK_BITS'(edge_tick);
      delta       = CW'(TICK_BITS'(now - last_edge_tick_ff));
      since_end   = CW'(TICK_BITS'(now - frame_end_tick_ff));
      since_start = CW'(TICK_BITS'(now - frame_start_tick_ff));

      cooldown_left = in_cooldown_ff && (since_end < CW'(cfg.cooldown_ticks));
      frame_open    = awaiting_frame_ff && !cooldown_left;
      // A frame that opens on this edge has zero elapsed ticks, so it closes
      // here only when the frame length is zero.
      closed = !cooldown_left &&
               (frame_open ? (cfg.frame_ticks == '0)
                           : (since_start >= CW'(cfg.frame_ticks)));

      start_mid = (edge_count_ff == irpfd_pkg::START_EDGE) || (start_seen_ff && !closed);
      active    = start_mid && edge_phase_ff;

      resync_hit = (CW'(cfg.resync_low) < delta) && (delta < CW'(cfg.resync_high));
      one_hit    = (CW'(cfg.one_low) < delta) && (delta < CW'(cfg.one_high)) &&
                   (edge_count_ff >= irpfd_pkg::START_EDGE);

      // Shifting past the word width drops the bit, which covers late bits.
      bit_idx  = irpfd_pkg::BIT_IDX_W'((edge_count_ff - irpfd_pkg::START_EDGE) >> 1);
      word_set = data_word_ff;
      if (active && one_hit) begin
         word_set = data_word_ff | ({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_idx);
      end

      frame_word = irpfd_pkg::FRAME_WORD_W'(word_set);
      key_code   = irpfd_pkg::lookup_key(irpfd_pkg::LOOKUP_W'(word_set));

      last_edge_tick_in   = now;
      frame_start_tick_in = frame_open ? now : frame_start_tick_ff;
      frame_end_tick_in   = closed ? now : frame_end_tick_ff;
      in_cooldown_in      = closed || cooldown_left;
      awaiting_frame_in   = closed || (awaiting_frame_ff && !frame_open);
      start_seen_in       = start_mid;
      edge_phase_in       = !(edge_phase_ff ^ (active && resync_hit));

      if (closed) begin
         edge_count_in = '0;
         data_word_in  = '0;
      end else begin
         edge_count_in = (edge_count_ff == irpfd_pkg::EDGE_COUNT_MAX) ?
                         edge_count_ff : edge_count_ff + 1'b1;
         data_word_in  = word_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_tick_ff   <= '0;
         frame_start_tick_ff <= '0;
         frame_end_tick_ff   <= '0;
         edge_phase_ff       <= 1'b0;
         start_seen_ff       <= 1'b0;
         awaiting_frame_ff   <= 1'b1;
         in_cooldown_ff      <= 1'b0;
         edge_count_ff       <= '0;
         data_word_ff        <= '0;
      end else if (step) begin
         last_edge_tick_ff   <= last_edge_tick_in;
         frame_start_tick_ff <= frame_start_tick_in;
         frame_end_tick_ff   <= frame_end_tick_in;
         edge_phase_ff       <= edge_phase_in;
         start_seen_ff       <= start_seen_in;
         awaiting_frame_ff   <= awaiting_frame_in;
         in_cooldown_ff      <= in_cooldown_in;
         edge_count_ff       <= edge_count_in;
         data_word_ff        <= data_word_in;
      end
   end

endmodule

`default_nettype wire

### rtl/irpfd_chk.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder port checker
// Watches the decoder's stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_frame_decoder_defines.svh"

module irpfd_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [irpfd_pkg::RSP_W-1:0]   rsp_tdata
);

   // No result may be pending right after reset.
   `IRPFD_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_tvalid, "result valid after reset")

   // The input only stalls behind a result that is not being taken.
   `IRPFD_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output backpressure")

   // Key codes stop at 16, the last entry of the code table.
   `IRPFD_ASSERT_IMPLY(a_key_range, clock, reset, rsp_tvalid, rsp_tdata[36:32] <= 5'd16, "key code out of range")

   // Every code word is 24 bits wide, so a recognized key has a clear top byte.
   `IRPFD_ASSERT_IMPLY(a_key_word, clock, reset, rsp_tvalid && (rsp_tdata[36:32] != 5'd0), rsp_tdata[31:24] == 8'd0, "key decoded from a wide word")

   `IRPFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")

endmodule

bind ir_pulse_frame_decoder irpfd_chk u_irpfd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse frame decoder testbench
// Feeds timestamped receiver edges to the decoder. Most edges form remote
// frames with random content, and the rest are stray and broken sequences.
// This runs under several timing register settings, the extremes among them.
// A scoreboard predicts every closed frame and checks each result beat,
// while both channels stall at random.
// ---------------------------------------------------------------------------
module tb;
   import irpfd_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 400;
   localparam int NUM_PLANS    = 6;
   localparam int SAT_EDGES    = 280;
   localparam int unsigned REG_UNMAPPED_LO = 6;
   localparam int unsigned REG_UNMAPPED_HI = 7;
   localparam logic [REG_W-1:0] REG_MAX = '1;

   typedef struct packed {
      logic [FRAME_WORD_W-1:0] word;
      logic [KEY_CODE_W-1:0]   key;
   } frame_result_t;

   typedef struct {
      logic [REG_W-1:0]       frame_len;
      logic [REG_W-1:0]       cool_len;
      logic [REG_W-1:0]       one_lo;
      logic [REG_W-1:0]       one_hi;
      logic [REG_W-1:0]       rs_lo;
      logic [REG_W-1:0]       rs_hi;
      logic [EDGE_TICK_W-1:0] one_iv;
      logic [EDGE_TICK_W-1:0] rs_iv;
      logic [EDGE_TICK_W-1:0] filler;
      int                     max_bits;
      bit                     framed;
      bit                     pressure;
      bit                     saturate;
      int                     edges;
   } timing_plan_t;

   class frame_scoreboard;
      logic [REG_W-1:0]        frame_len, cool_len, one_lo, one_hi, rs_lo, rs_hi;
      logic [EDGE_TICK_W-1:0]  last_tick, start_tick, end_tick;
      bit                      phase, start_seen, awaiting, cooling;
      logic [EDGE_COUNT_W-1:0] edge_cnt;
      logic [FRAME_WORD_W-1:0] word_acc;
      frame_result_t           expected_frames[$];
      int                      errors, edge_total, frames_seen, keyed_frames;

      function new();
         frame_len  = FRAME_TICKS_RST;
         cool_len   = COOLDOWN_TICKS_RST;
         one_lo     = ONE_LOW_RST;
         one_hi     = ONE_HIGH_RST;
         rs_lo      = RESYNC_LOW_RST;
         rs_hi      = RESYNC_HIGH_RST;
         last_tick  = '0;
         start_tick = '0;
         end_tick   = '0;
         phase      = 1'b0;
         start_seen = 1'b0;
         awaiting   = 1'b1;
         cooling    = 1'b0;
         edge_cnt   = '0;
         word_acc   = '0;
      endfunction

      function void set_reg(int unsigned idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_FRAME_TICKS:    frame_len = data[REG_W-1:0];
            REG_COOLDOWN_TICKS: cool_len  = data[REG_W-1:0];
            REG_ONE_LOW:        one_lo    = data[REG_W-1:0];
            REG_ONE_HIGH:       one_hi    = data[REG_W-1:0];
            REG_RESYNC_LOW:     rs_lo     = data[REG_W-1:0];
            REG_RESYNC_HIGH:    rs_hi     = data[REG_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [KEY_CODE_W-1:0] key_of(logic [FRAME_WORD_W-1:0] w);
         logic [KEY_CODE_W-1:0] k;
         k = NO_KEY;
         for (int i = 0; i < NUM_CODES; i++) begin
            if (w == FRAME_WORD_W'(CODE_WORDS[i])) k = KEY_CODE_W'(i + 1);
         end
         return k;
      endfunction

      // Advance the decoder state by one edge; a closing edge queues a result.
      function void note_edge(logic [EDGE_TICK_W-1:0] now);
         logic [EDGE_TICK_W-1:0]  gap;
         logic [EDGE_COUNT_W-1:0] bit_idx;
         bit                      closed;
         frame_result_t           res;
         gap        = now - last_tick;
         last_tick  = now;
         closed     = 1'b0;
         edge_total++;
         if (cooling && (now - end_tick) >= cool_len) cooling = 1'b0;
         if (awaiting && !cooling) begin
            awaiting   = 1'b0;
            start_tick = now;
         end
         if (!cooling && (now - start_tick) >= frame_len) begin
            awaiting   = 1'b1;
            end_tick   = now;
            cooling    = 1'b1;
            start_seen = 1'b0;
            closed     = 1'b1;
         end
         if (edge_cnt == START_EDGE) start_seen = 1'b1;
         if (start_seen && phase) begin
            if (rs_lo < gap && gap < rs_hi) phase = ~phase;
            if (one_lo < gap && gap < one_hi && edge_cnt >= START_EDGE) begin
               bit_idx = (edge_cnt - START_EDGE) >> 1;
               if (bit_idx < FRAME_WORD_W) word_acc[bit_idx] = 1'b1;
            end
         end
         if (edge_cnt != EDGE_COUNT_MAX) edge_cnt++;
         phase = ~phase;
         if (closed) begin
            res.word = word_acc;
            res.key  = key_of(word_acc);
            expected_frames.push_back(res);
            word_acc = '0;
            edge_cnt = '0;
         end
      endfunction

      function void check_frame(logic [RSP_W-1:0] beat);
         frame_result_t           want;
         logic [FRAME_WORD_W-1:0] got_word;
         logic [KEY_CODE_W-1:0]   got_key;
         got_word = beat[FRAME_WORD_W-1:0];
         got_key  = beat[FRAME_WORD_W +: KEY_CODE_W];
         frames_seen++;
         if (expected_frames.size() == 0) begin
            $error("result beat with no frame expected: frame_word %h key_code %0d",
                   got_word, got_key);
            errors++;
            return;
         end
         want = expected_frames.pop_front();
         if (got_word !== want.word) begin
            $error("frame_word mismatch: expected %h, actual %h", want.word, got_word);
            errors++;
         end
         if (got_key !== want.key) begin
            $error("key_code mismatch: expected %0d, actual %0d", want.key, got_key);
            errors++;
         end
         if (want.key != NO_KEY) keyed_frames++;
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      function void report_leftover();
         if (expected_frames.size() != 0) begin
            $error("%0d expected frames never arrived", expected_frames.size());
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_scoreboard sb;
   int cycle_count = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int rsp_hold = 0;
   int plans_applied = 0;

   ir_pulse_frame_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Random stalls, broken up by stretches of back-to-back beats.
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic logic [EDGE_TICK_W-1:0] stray_interval();
      case ($urandom_range(0, 5))
         0:       return EDGE_TICK_W'($urandom_range(0, 255));
         1:       return $urandom;
         2:       return EDGE_TICK_W'(sb.one_lo) + $urandom_range(0, 2);
         3:       return EDGE_TICK_W'(sb.one_hi) - $urandom_range(0, 2);
         4:       return EDGE_TICK_W'(sb.rs_lo) + $urandom_range(0, 2);
         default: return EDGE_TICK_W'(sb.rs_hi) - $urandom_range(0, 2);
      endcase
   endfunction

   task automatic drive_edge(input logic [EDGE_TICK_W-1:0] tick);
      int gap_cycles;
      gap_cycles = pick_gap(req_calm);
      if (gap_cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap_cycles - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(tick);
      do @(posedge clock); while (!req_tready);
      sb.note_edge(tick);
   endtask

   // Stop offering edges and wait until every predicted frame has come out.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int unsigned idx, input logic [REG_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      // The upper byte is junk that the block must drop.
      data = {8'($urandom), value};
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_plan(input timing_plan_t p);
      settle();
      csr_write(REG_FRAME_TICKS, p.frame_len);
      csr_write(REG_COOLDOWN_TICKS, p.cool_len);
      csr_write(REG_ONE_LOW, p.one_lo);
      csr_write(REG_ONE_HIGH, p.one_hi);
      csr_write(REG_RESYNC_LOW, p.rs_lo);
      csr_write(REG_RESYNC_HIGH, p.rs_hi);
      if ($urandom_range(0, 1) == 0) csr_write(REG_UNMAPPED_LO, REG_W'($urandom));
      else csr_write(REG_UNMAPPED_HI, REG_W'($urandom));
      plans_applied++;
   endtask

   // One remote frame: close any open frame, wait out the cooldown, then send
   // header and data edges whose spacing encodes the chosen word.
   task automatic send_frame(input timing_plan_t p);
      logic [39:0]            word;
      logic [EDGE_TICK_W-1:0] iv;
      int                     nbits;
      int                     bit_at;
      bit                     active;
      case ($urandom_range(0, 3))
         0, 1: begin
            word  = 40'(CODE_WORDS[$urandom_range(0, NUM_CODES - 1)]);
            nbits = 24;
         end
         2: begin
            word  = {8'($urandom), 32'($urandom)};
            nbits = $urandom_range(1, 40);
         end
         default: begin
            // One bit away from a known code.
            word  = 40'(CODE_WORDS[$urandom_range(0, NUM_CODES - 1)])
                    ^ (40'd1 << $urandom_range(0, 23));
            nbits = 24;
         end
      endcase
      if (nbits > p.max_bits) nbits = p.max_bits;
      if ($urandom_range(0, 7) == 0) nbits = $urandom_range(0, nbits);
      if (!sb.awaiting) drive_edge(sb.start_tick + EDGE_TICK_W'(p.frame_len));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) drive_edge(sb.last_tick + p.filler);
      if (sb.cooling)
         drive_edge(sb.end_tick + EDGE_TICK_W'(p.cool_len) + $urandom_range(0, 2));
      for (int guard = 0; guard < 100; guard++) begin
         bit_at = 0;
         if (sb.edge_cnt >= START_EDGE) begin
            bit_at = int'((sb.edge_cnt - START_EDGE) >> 1);
            if (bit_at >= nbits) break;
         end
         active = sb.phase && sb.edge_cnt >= START_EDGE
                  && (sb.start_seen || sb.edge_cnt == START_EDGE);
         if ($urandom_range(0, 60) == 0) iv = stray_interval();
         else if (active && $urandom_range(0, 15) == 0) iv = p.rs_iv;
         else if (active && word[bit_at]) iv = p.one_iv;
         else iv = p.filler;
         drive_edge(sb.last_tick + iv);
      end
      if (!sb.awaiting)
         drive_edge(sb.start_tick + EDGE_TICK_W'(p.frame_len) + $urandom_range(0, 3));
   endtask

   task automatic run_plan(input timing_plan_t p);
      int  target;
      bit  paused;
      apply_plan(p);
      target = sb.edge_total + p.edges;
      paused = 1'b0;
      if (p.pressure) begin
         // The sink stops for a long while and the source keeps pushing.
         rsp_hold = HOLD_CYCLES;
         req_calm = 80;
      end
      if (p.saturate)
         repeat (SAT_EDGES) drive_edge(sb.last_tick + $urandom_range(1, 16));
      while (sb.edge_total < target) begin
         if (p.framed && $urandom_range(0, 7) != 0) send_frame(p);
         else repeat ($urandom_range(1, 8)) drive_edge(sb.last_tick + stray_interval());
         if (!paused && sb.edge_total >= target - p.edges / 2) begin
            settle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin : result_sink
      int wait_cycles;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (rsp_hold - 1) @(negedge clock);
            rsp_hold = 0;
         end
         wait_cycles = pick_gap(rsp_calm);
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_frame(rsp_tdata);
      end
   end

   initial begin : stimulus
      timing_plan_t plan [NUM_PLANS];
      timing_plan_t fourth_edge_close;
      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      plan[0] = '{FRAME_TICKS_RST, COOLDOWN_TICKS_RST, ONE_LOW_RST, ONE_HIGH_RST,
                  RESYNC_LOW_RST, RESYNC_HIGH_RST, 32'd195000, 32'd72000, 32'd20000,
                  24, 1'b1, 1'b0, 1'b0, 300};
      plan[1] = '{24'd30000, 24'd3000, 24'd190, 24'd200, 24'd70, 24'd74,
                  32'd195, 32'd72, 32'd40, 40, 1'b1, 1'b0, 1'b0, 400};
      // Zero frame length and wide-open ranges: every edge closes a frame.
      plan[2] = '{24'd0, 24'd0, 24'd0, REG_MAX, 24'd0, REG_MAX,
                  32'd1000, 32'd1000, 32'd1000, 40, 1'b0, 1'b1, 1'b0, 250};
      // Longest frame and cooldown with empty ranges; the edge count saturates.
      plan[3] = '{REG_MAX, REG_MAX, REG_MAX - 24'd1, REG_MAX, REG_MAX, REG_MAX,
                  32'd1000, 32'd1000, 32'd10, 40, 1'b0, 1'b0, 1'b1, 350};
      // Overlapping ranges: one interval both sets a bit and flips the phase.
      plan[4] = '{24'd40000, 24'd0, 24'd100, 24'd300, 24'd100, 24'd300,
                  32'd200, 32'd150, 32'd30, 40, 1'b1, 1'b0, 1'b0, 300};
      plan[5] = '{24'd20000, 24'd0, 24'd190, 24'd200, 24'd70, 24'd74,
                  32'd195, 32'd72, 32'd40, 32, 1'b1, 1'b0, 1'b0, 250};
      // Frames close on the start edge itself, leaving the start flag set early.
      fourth_edge_close = '{24'd585, 24'd0, 24'd190, 24'd200, 24'd70, 24'd74,
                            32'd195, 32'd72, 32'd40, 32, 1'b0, 1'b0, 1'b0, 0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drive_edge(32'h0000_0000);
      drive_edge(32'hFFFF_FFFF);
      drive_edge(32'h0000_0004);
      drive_edge(32'h5555_5555);
      drive_edge(32'hAAAA_AAAA);
      drive_edge(32'h8000_0000);
      drive_edge(32'h7FFF_FFFF);
      apply_plan(fourth_edge_close);
      repeat (14) drive_edge(sb.last_tick + 32'd195);

      for (int i = 0; i < NUM_PLANS; i++) run_plan(plan[i]);
      settle();
      repeat (10) @(posedge clock);
      sb.report_leftover();

      $display("Sent %0d edge beats and checked %0d frames, %0d of them carrying a key.",
               sb.edge_total, sb.frames_seen, sb.keyed_frames);
      $display("Used %0d register settings, with long sink stalls and source pauses.",
               plans_applied);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/irpfd_pkg.sv
rtl/irpfd_csr.sv
rtl/irpfd_core.sv
rtl/ir_pulse_frame_decoder.sv
rtl/irpfd_chk.sv
sim/tb.sv
